/* sv/sdc_pkg.sv */
package sdc_pkg;

	localparam int HDR_BYTES = 8;
	localparam int Q_DEPTH_DEF = 4;

	localparam logic [15:0] CRC_POLY = 16'hE593;
	localparam logic [7:0] CMD_A = 8'h53;
	localparam logic [7:0] CMD_B = 8'h63;
	localparam logic [7:0] CMD_C = 8'h82;
	localparam logic [15:0] CMD_A_LO_SEED = 16'hF69C;
	localparam logic [15:0] XOR_A_HI = 16'h1c6d;
	localparam logic [15:0] XOR_B_HI = 16'hf993;
	localparam logic [15:0] XOR_B_LO = 16'h98ef;
	localparam logic [15:0] XOR_C_HI = 16'hcc64;
	localparam logic [15:0] XOR_C_LO = 16'hcdbd;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_CMD = 2'd1;
	localparam logic [1:0] STATUS_SHORT = 2'd2;

	typedef logic [7:0] mat_t [16];

	localparam mat_t MAT_A_HI = '{8'h1c, 8'h26, 8'h52, 8'h24, 8'h48, 8'h70, 8'h62, 8'h44,
		8'h16, 8'h4c, 8'h64, 8'h28, 8'h52, 8'h5a, 8'h56, 8'h30};
	localparam mat_t MAT_B_HI = '{8'h0e, 8'h36, 8'h12, 8'h72, 8'h30, 8'h6c, 8'h0c, 8'h68,
		8'h5e, 8'h40, 8'h54, 8'h24, 8'h48, 8'h62, 8'h6e, 8'h06};
	localparam mat_t MAT_B_LO = '{8'h5c, 8'h40, 8'h7a, 8'h52, 8'h24, 8'h30, 8'h62, 8'h44,
		8'h54, 8'h52, 8'h24, 8'h32, 8'h42, 8'h20, 8'h38, 8'h2e};
	localparam mat_t MAT_C_HI = '{8'h10, 8'h1a, 8'h3a, 8'h1e, 8'h3e, 8'h30, 8'h3e, 8'h16,
		8'h14, 8'h38, 8'h06, 8'h28, 8'h24, 8'h0a, 8'h04, 8'h06};
	localparam mat_t MAT_C_LO = '{8'h34, 8'h28, 8'h26, 8'h0e, 8'h1c, 8'h0e, 8'h1c, 8'h38,
		8'h04, 8'h0a, 8'h20, 8'h02, 8'h32, 8'h12, 8'h26, 8'h3a};

	typedef enum logic [1:0] {
		OP_NOP,
		OP_FEED,
		OP_SEED
	} op_t;

	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_C
	} cmd_sel_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] crc_value;
		logic [1:0]  status;
	} out_item_t;

	// one classified byte on its way from front to back
	typedef struct packed {
		op_t        op;
		cmd_sel_t   sel;
		logic [7:0] data;
		logic       hdr_wr;
		logic [2:0] hdr_idx;
		logic [3:0] replay_n;
		logic       last;
		logic [1:0] status;
	} entry_t;

	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// gf(2) matrix times sequence byte, then xor constant
	function automatic logic [15:0] seed_of(logic [7:0] seq, mat_t rows, logic [15:0] k);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = ^(rows[i] & seq);
		end
		return r ^ k;
	endfunction

endpackage

/* sv/sdc_front.sv */
module sdc_front
	import sdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	input  logic     q_full,
	output logic     push,
	output entry_t   push_entry
);

	logic [15:0] count_q;
	logic [15:0] covered_q;
	logic [7:0]  len_lo_q;
	logic        bad_q;
	cmd_sel_t    sel_q;

	logic [15:0] count_next;
	logic        in_hdr;
	logic        known_cmd;
	cmd_sel_t    sel_new;

	assign push = start && !q_full;
	assign in_hdr = count_q < 16'(HDR_BYTES);
	assign count_next = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;

	always_comb begin
		known_cmd = 1'b1;
		sel_new = SEL_A;
		case (item.data_byte)
			CMD_A: sel_new = SEL_A;
			CMD_B: sel_new = SEL_B;
			CMD_C: sel_new = SEL_C;
			default: known_cmd = 1'b0;
		endcase
	end

	always_comb begin
		push_entry.op = OP_NOP;
		push_entry.sel = sel_q;
		push_entry.data = item.data_byte;
		push_entry.hdr_wr = in_hdr;
		push_entry.hdr_idx = count_q[2:0];
		push_entry.replay_n = (covered_q < 16'(HDR_BYTES)) ? covered_q[3:0]
			: 4'(HDR_BYTES);
		push_entry.last = item.last;
		if (count_q == 16'(HDR_BYTES - 1)) begin
			push_entry.op = bad_q ? OP_NOP : OP_SEED;
		end else if (!in_hdr && count_q < covered_q && !bad_q) begin
			push_entry.op = OP_FEED;
		end
		if (count_next < 16'(HDR_BYTES) || count_next < covered_q)
			push_entry.status = STATUS_SHORT;
		else if (bad_q)
			push_entry.status = STATUS_BAD_CMD;
		else
			push_entry.status = STATUS_OK;
	end

	// length and command are taken early; before byte 7 they only matter for status,
	// and a message that ends there is short anyway
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			covered_q <= '0;
			bad_q <= 1'b0;
		end else if (push) begin
			if (item.last) begin
				count_q <= '0;
				covered_q <= '0;
				bad_q <= 1'b0;
			end else begin
				count_q <= count_next;
				if (count_q == 16'd1)
					covered_q <= {item.data_byte, len_lo_q} - 16'd1;
				if (count_q == 16'd2)
					bad_q <= !known_cmd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (count_q == 16'd0)
				len_lo_q <= item.data_byte;
			if (count_q == 16'd2)
				sel_q <= sel_new;
		end
	end

endmodule

/* sv/sdc_queue.sv */
module sdc_queue
	import sdc_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         slot_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  fill_q;

	assign empty = (fill_q == '0);
	assign full = (fill_q == CW'(DEPTH));
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				fill_q <= fill_q + CW'(1);
			else if (pop && !push)
				fill_q <= fill_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_entry;
	end

endmodule

/* sv/sdc_back.sv */
module sdc_back
	import sdc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  logic      q_empty,
	output logic      pop,
	output logic      done,
	output out_item_t result
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REPLAY = 4'b0010,
		ST_EXT1   = 4'b0100,
		ST_EXT2   = 4'b1000
	} state_t;

	state_t      state_q;
	logic        done_q;
	out_item_t   result_q;
	logic [7:0]  header_q [HDR_BYTES];
	logic [15:0] hi_q;
	logic [15:0] lo_q;
	logic [2:0]  rp_q;
	logic [3:0]  replay_n_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic        start_replay;
	logic        rp_end;
	logic        finish;
	logic [1:0]  fin_status;
	logic [7:0]  hi_byte;
	logic [7:0]  lo_byte;
	logic [15:0] hi_step;
	logic [15:0] lo_step;
	logic [15:0] seed_hi;
	logic [15:0] seed_lo;

	assign pop = (state_q == ST_IDLE) && !q_empty;
	assign start_replay = pop && head.op == OP_SEED && head.replay_n != 4'd0;
	assign rp_end = ({1'b0, rp_q} == replay_n_q - 4'd1);
	assign finish = (pop && head.last && !start_replay)
		|| (state_q == ST_REPLAY && rp_end && last_q);
	assign fin_status = pop ? head.status : status_q;

	// one shared byte step per crc; the extension feeds the high crc into the low one
	always_comb begin
		hi_byte = pop ? head.data : header_q[rp_q];
		lo_byte = hi_byte;
		if (state_q == ST_EXT1)
			lo_byte = hi_q[7:0];
		else if (state_q == ST_EXT2)
			lo_byte = hi_q[15:8];
	end

	assign hi_step = crc_byte(hi_q, hi_byte);
	assign lo_step = crc_byte(lo_q, lo_byte);

	always_comb begin
		case (head.sel)
			SEL_A: begin
				seed_hi = seed_of(head.data, MAT_A_HI, XOR_A_HI);
				seed_lo = CMD_A_LO_SEED;
			end
			SEL_B: begin
				seed_hi = seed_of(head.data, MAT_B_HI, XOR_B_HI);
				seed_lo = seed_of(head.data, MAT_B_LO, XOR_B_LO);
			end
			SEL_C: begin
				seed_hi = seed_of(head.data, MAT_C_HI, XOR_C_HI);
				seed_lo = seed_of(head.data, MAT_C_LO, XOR_C_LO);
			end
			default: begin
				seed_hi = '0;
				seed_lo = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start_replay) begin
						state_q <= ST_REPLAY;
					end else if (finish) begin
						if (fin_status == STATUS_OK)
							state_q <= ST_EXT1;
						else
							done_q <= 1'b1;
					end
				end
				ST_REPLAY: begin
					if (rp_end) begin
						if (finish && fin_status == STATUS_OK) begin
							state_q <= ST_EXT1;
						end else begin
							state_q <= ST_IDLE;
							done_q <= finish;
						end
					end
				end
				ST_EXT1: state_q <= ST_EXT2;
				ST_EXT2: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.hdr_wr)
				header_q[head.hdr_idx] <= head.data;
			last_q <= head.last;
			status_q <= head.status;
			replay_n_q <= head.replay_n;
			rp_q <= '0;
			case (head.op)
				OP_SEED: begin
					hi_q <= seed_hi;
					lo_q <= seed_lo;
				end
				OP_FEED: begin
					hi_q <= hi_step;
					lo_q <= lo_step;
				end
				default: ;
			endcase
		end else if (state_q == ST_REPLAY) begin
			hi_q <= hi_step;
			lo_q <= lo_step;
			rp_q <= rp_q + 3'd1;
		end else if (state_q == ST_EXT1) begin
			lo_q <= lo_step;
		end
		if (state_q == ST_EXT2) begin
			result_q.crc_value <= {hi_q, lo_step};
			result_q.status <= STATUS_OK;
		end else if (finish && fin_status != STATUS_OK) begin
			result_q.crc_value <= '0;
			result_q.status <= fin_status;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

/* sv/seeded_dual_crc16_message_check_core.sv */
// Message check: takes one message byte per transfer (start high while busy is low) and
// pulses done for one cycle with the 32-bit dual crc and a status after the final byte.
// A front stage classifies bytes at one per cycle while the queue is not full and hands
// them through a small queue (QUEUE_DEPTH entries) to the crc engine; busy is high only
// while that queue is full. Header byte 7 loads the seed, and the engine then replays up
// to eight covered header bytes into both crcs. A well-formed final byte is followed by
// the extension states ST_EXT1 and ST_EXT2, and done is registered after them. Results
// cannot be held off by the receiver: capture the result port in the cycle done is high.
module seeded_dual_crc16_message_check_core
	import sdc_pkg::*;
#(
	parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;

	assign busy = q_full;

	sdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	sdc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	sdc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_empty(q_empty),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

/* tb/sv/seeded_dual_crc16_message_check_core_tb.sv */
`timescale 1ns / 100ps

module seeded_dual_crc16_message_check_core_tb;
	import sdc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BYTES = 475;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	typedef logic [7:0] row_set_t [16];

	localparam row_set_t ROWS_A_HI = '{8'h1c, 8'h26, 8'h52, 8'h24, 8'h48, 8'h70, 8'h62, 8'h44,
		8'h16, 8'h4c, 8'h64, 8'h28, 8'h52, 8'h5a, 8'h56, 8'h30};
	localparam row_set_t ROWS_B_HI = '{8'h0e, 8'h36, 8'h12, 8'h72, 8'h30, 8'h6c, 8'h0c, 8'h68,
		8'h5e, 8'h40, 8'h54, 8'h24, 8'h48, 8'h62, 8'h6e, 8'h06};
	localparam row_set_t ROWS_B_LO = '{8'h5c, 8'h40, 8'h7a, 8'h52, 8'h24, 8'h30, 8'h62, 8'h44,
		8'h54, 8'h52, 8'h24, 8'h32, 8'h42, 8'h20, 8'h38, 8'h2e};
	localparam row_set_t ROWS_C_HI = '{8'h10, 8'h1a, 8'h3a, 8'h1e, 8'h3e, 8'h30, 8'h3e, 8'h16,
		8'h14, 8'h38, 8'h06, 8'h28, 8'h24, 8'h0a, 8'h04, 8'h06};
	localparam row_set_t ROWS_C_LO = '{8'h34, 8'h28, 8'h26, 8'h0e, 8'h1c, 8'h0e, 8'h1c, 8'h38,
		8'h04, 8'h0a, 8'h20, 8'h02, 8'h32, 8'h12, 8'h26, 8'h3a};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic done;
	out_item_t result;

	in_item_t pending_bytes [$];
	out_item_t expected_crc_q [$];
	int gap_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	// message state of the predictor
	logic [7:0] hdr_bytes [8];
	logic [15:0] msg_count = '0;
	logic [15:0] cover_len = '0;
	logic [15:0] hi_crc = '0;
	logic [15:0] lo_crc = '0;
	logic cmd_bad = 1'b0;

	seeded_dual_crc16_message_check_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// parity of each row masked by the sequence byte gives one seed bit
	function automatic logic [15:0] seq_seed(logic [7:0] seq, row_set_t rows, logic [15:0] mask);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) r[i] = ^(rows[i] & seq);
		return r ^ mask;
	endfunction

	function automatic void advance_message(input in_item_t b, output logic got,
			output out_item_t res);
		logic [15:0] idx;
		logic [7:0] seq;
		logic [15:0] ext;
		idx = msg_count;
		got = 1'b0;
		res = '0;
		if (idx < HDR_BYTES) hdr_bytes[idx[2:0]] = b.data_byte;
		if (idx == HDR_BYTES - 1) begin
			seq = hdr_bytes[7];
			cover_len = {hdr_bytes[1], hdr_bytes[0]} - 16'd1;
			cmd_bad = 1'b0;
			case (hdr_bytes[2])
				CMD_A: begin
					hi_crc = seq_seed(seq, ROWS_A_HI, XOR_A_HI);
					lo_crc = CMD_A_LO_SEED;
				end
				CMD_B: begin
					hi_crc = seq_seed(seq, ROWS_B_HI, XOR_B_HI);
					lo_crc = seq_seed(seq, ROWS_B_LO, XOR_B_LO);
				end
				CMD_C: begin
					hi_crc = seq_seed(seq, ROWS_C_HI, XOR_C_HI);
					lo_crc = seq_seed(seq, ROWS_C_LO, XOR_C_LO);
				end
				default: begin
					cmd_bad = 1'b1;
					hi_crc = '0;
					lo_crc = '0;
				end
			endcase
			// header replay, limited by the covered length
			if (!cmd_bad) begin
				for (int i = 0; i < HDR_BYTES; i++) begin
					if (i < cover_len) begin
						hi_crc = crc16_step(hi_crc, hdr_bytes[i]);
						lo_crc = crc16_step(lo_crc, hdr_bytes[i]);
					end
				end
			end
		end else if (idx >= HDR_BYTES && idx < cover_len && !cmd_bad) begin
			hi_crc = crc16_step(hi_crc, b.data_byte);
			lo_crc = crc16_step(lo_crc, b.data_byte);
		end
		if (msg_count != 16'hFFFF) msg_count = msg_count + 16'd1;
		if (b.last) begin
			got = 1'b1;
			if (msg_count < HDR_BYTES || msg_count < cover_len) begin
				res.status = STATUS_SHORT;
			end else if (cmd_bad) begin
				res.status = STATUS_BAD_CMD;
			end else begin
				ext = crc16_step(lo_crc, hi_crc[7:0]);
				ext = crc16_step(ext, hi_crc[15:8]);
				res.crc_value = {hi_crc, ext};
				res.status = STATUS_OK;
			end
			msg_count = '0;
			cover_len = '0;
			hi_crc = '0;
			lo_crc = '0;
			cmd_bad = 1'b0;
		end
	endfunction

	task automatic report_failure(string what, out_item_t want, out_item_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%s: expected crc %08h status %0d, got crc %08h status %0d",
				what, want.crc_value, want.status, got.crc_value, got.status);
	endtask

	// driver: a byte transfers on an edge with start high and busy low
	always @(posedge clk) begin : driver
		logic got;
		out_item_t res;
		if (arst_n) begin
			if (start && !busy) begin
				advance_message(item, got, res);
				if (got) expected_crc_q.push_back(res);
			end
			if (!start || !busy) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
					item <= pending_bytes.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: done marks a one-cycle result that cannot be held off
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n && done) begin
			if (expected_crc_q.size() == 0) begin
				report_failure("unexpected result", '0, result);
			end else begin
				want = expected_crc_q.pop_front();
				if (result.crc_value !== want.crc_value || result.status !== want.status)
					report_failure("result mismatch", want, result);
			end
		end
	end

	task automatic queue_message(int n, logic [15:0] len_field, logic [7:0] cmd,
			logic [7:0] seq);
		in_item_t b;
		for (int i = 0; i < n; i++) begin
			case (i)
				0: b.data_byte = len_field[7:0];
				1: b.data_byte = len_field[15:8];
				2: b.data_byte = cmd;
				7: b.data_byte = seq;
				default: b.data_byte = 8'($urandom);
			endcase
			b.last = (i == n - 1);
			pending_bytes.push_back(b);
		end
	endtask

	// mostly well-formed messages, some short, some with odd lengths or commands
	task automatic queue_random_message(output int n);
		int r;
		int len_field;
		logic [7:0] cmd;
		r = $urandom_range(99);
		if (r < 8) n = $urandom_range(1, 7);
		else if (r < 90) n = $urandom_range(8, 40);
		else n = $urandom_range(41, 80);
		r = $urandom_range(99);
		if (r < 30) cmd = CMD_A;
		else if (r < 60) cmd = CMD_B;
		else if (r < 90) cmd = CMD_C;
		else cmd = 8'($urandom);
		r = $urandom_range(99);
		if (r < 25) len_field = n;
		else if (r < 50) len_field = n + 1;
		else if (r < 65) len_field = n - $urandom_range(1, 8);
		else if (r < 80) len_field = $urandom_range(0, 9);
		else if (r < 90) len_field = $urandom_range(0, 65535);
		else len_field = n + $urandom_range(2, 5);
		queue_message(n, 16'(len_field & 16'hFFFF), cmd, 8'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || start || expected_crc_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int phase_gap [4];
		int queued;
		int n;
		phase_gap = '{0, 84, 0, 25};
		for (int i = 0; i < HDR_BYTES; i++) hdr_bytes[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every command, short, unknown, wrapped and partial lengths
		queue_message(1, 16'h0009, CMD_A, 8'h00);
		queue_message(8, 16'h0009, CMD_A, 8'h00);
		queue_message(9, 16'h000A, CMD_B, 8'hFF);
		queue_message(8, 16'h0001, CMD_C, 8'h5A);
		queue_message(8, 16'h0009, 8'h00, 8'($urandom));
		queue_message(8, 16'h0000, 8'hFF, 8'($urandom));
		queue_message(10, 16'h0014, CMD_A, 8'($urandom));
		queue_message(12, 16'h0005, CMD_B, 8'($urandom));
		wait_drained();

		foreach (phase_gap[p]) begin
			gap_pct = phase_gap[p];
			queued = 0;
			while (queued < PHASE_BYTES) begin
				queue_random_message(n);
				queued += n;
			end
			// hold back new bytes until every pending result has come out
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		fail_count += expected_crc_q.size();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d failures", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
